// File: design/mbtrs_pkg.sv
package mbtrs_pkg;

    // Table size and frame limits
    localparam int NUM_REGS  = 10;
    localparam int MAX_FRAME = 512;
    localparam int HDR_LEN   = 12;
    localparam int MAX_RESP  = 29;
    localparam int MAX_QTY   = 10;

    localparam int POS_W  = $clog2(MAX_FRAME + 1);
    localparam int IDX_W  = $clog2(MAX_FRAME / 2);
    localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int K_W    = $clog2(MAX_RESP + 1);
    localparam int HDR_AW = $clog2(HDR_LEN);
    localparam int Q_W    = $clog2(MAX_QTY + 1);

    // Frame byte positions
    localparam int MIN_FRAME  = 8;
    localparam int DATA_START = 13;
    localparam int POS_LEN_LO = 5;
    localparam int POS_FUNC   = 7;
    localparam int POS_ARG    = 8;
    localparam int POS_DATA   = 9;
    localparam int ECHO_LEN   = 12;
    localparam int EXC_LEN    = 9;

    // Function codes and response constants
    localparam logic [7:0] FUNC_READ      = 8'd3;
    localparam logic [7:0] FUNC_WRITE_ONE = 8'd6;
    localparam logic [7:0] FUNC_WRITE_MUL = 8'd16;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FN = 8'h01;
    localparam logic [7:0] LEN_SHORT_PDU  = 8'd3;
    localparam logic [7:0] LEN_WRITE_PDU  = 8'd6;

    localparam logic [15:0] REG_PRESET [10] = '{
        16'd123, 16'd456, 16'd789, 16'd321, 16'd654,
        16'd987, 16'd111, 16'd222, 16'd333, 16'd444
    };

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_READ,
        MODE_ECHO,
        MODE_WMULTI,
        MODE_EXC
    } t_mode;

    typedef struct packed {
        logic take;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic no_resp;
        logic last_byte;
        logic out_free;
    } t_sts;

endpackage

// File: design/mbtrs_ctrl.sv
module mbtrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_frame_end,
    input  mbtrs_pkg::t_sts i_sts,
    output mbtrs_pkg::t_cmd o_cmd,
    output logic           o_ready
);
    import mbtrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        o_cmd.take   = r_ready && i_valid;
        o_cmd.decide = (r_state == S_DECIDE);
        o_cmd.emit   = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_frame_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_sts.no_resp ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (o_cmd.emit && i_sts.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

    a_end_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_frame_end) |=> (r_state == S_DECIDE))
        else $error("frame end did not start a response decision");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> (r_state == S_IDLE))
        else $error("byte taken outside idle");

endmodule

// File: design/mbtrs_dp.sv
module mbtrs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbtrs_pkg::t_cmd i_cmd,
    input  logic [7:0]      i_req_byte,
    input  logic            i_out_ready,
    output mbtrs_pkg::t_sts o_sts,
    output logic            o_out_valid,
    output logic [7:0]      o_resp_byte,
    output logic            o_resp_end
);
    import mbtrs_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_hdr [HDR_LEN];
    logic [15:0]       r_regs [NUM_REGS];
    logic [7:0]        r_pend;
    logic [IDX_W-1:0]  r_widx;
    t_mode             r_mode, n_mode;
    logic [K_W-1:0]    r_len, n_len;
    logic [Q_W-1:0]    r_qty, n_qty;
    logic [K_W-1:0]    r_k;
    logic [16:0]       r_rd_addr;
    logic              r_out_valid;
    logic [7:0]        r_out_byte, n_byte;
    logic              r_out_end;

    logic [15:0] hdr_pid, hdr_start, hdr_qty;
    logic [7:0]  func;
    logic        take_en, in_data, multi, hi_byte, word_done;
    logic [16:0] word_addr;
    logic        wr_en;
    logic [16:0] wr_addr;
    logic [15:0] wr_data;
    logic [7:0]  hdr_k, two_q;
    logic [15:0] rd_val;

    assign hdr_pid   = {r_hdr[2], r_hdr[3]};
    assign hdr_start = {r_hdr[8], r_hdr[9]};
    assign hdr_qty   = {r_hdr[10], r_hdr[11]};
    assign func      = r_hdr[POS_FUNC];

    // Byte intake and write-multiple data words
    assign take_en   = i_cmd.take && (r_pos < POS_W'(MAX_FRAME));
    assign in_data   = (r_pos >= POS_W'(DATA_START));
    assign multi     = (hdr_pid == 16'd0) && (func == FUNC_WRITE_MUL);
    assign hi_byte   = take_en && in_data && multi && r_pos[0];
    assign word_done = take_en && in_data && multi && !r_pos[0];
    assign word_addr = 17'(hdr_start) + 17'(r_widx);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = word_addr;
        wr_data = {r_pend, i_req_byte};
        if (word_done && (16'(r_widx) < hdr_qty)) begin
            wr_en = 1'b1;
        end else if (i_cmd.decide && (n_mode == MODE_ECHO)) begin
            wr_en   = 1'b1;
            wr_addr = 17'(hdr_start);
            wr_data = hdr_qty;
        end
        if (wr_addr >= 17'(NUM_REGS)) begin
            wr_en = 1'b0;
        end
    end

    // Response decision
    always_comb begin
        n_qty = (hdr_qty > 16'(MAX_QTY)) ? Q_W'(MAX_QTY) : hdr_qty[Q_W-1:0];
        if ((r_pos < POS_W'(MIN_FRAME)) || (hdr_pid != 16'd0)) begin
            n_mode = MODE_NONE;
        end else if ((func == FUNC_READ) && (r_pos >= POS_W'(HDR_LEN))) begin
            n_mode = MODE_READ;
        end else if ((func == FUNC_WRITE_ONE) && (r_pos >= POS_W'(HDR_LEN))) begin
            n_mode = MODE_ECHO;
        end else if ((func == FUNC_WRITE_MUL) && (r_pos >= POS_W'(DATA_START))) begin
            n_mode = MODE_WMULTI;
        end else begin
            n_mode = MODE_EXC;
        end
        case (n_mode)
            MODE_READ:   n_len = K_W'(POS_DATA) + K_W'({n_qty, 1'b0});
            MODE_ECHO:   n_len = K_W'(ECHO_LEN);
            MODE_WMULTI: n_len = K_W'(ECHO_LEN);
            MODE_EXC:    n_len = K_W'(EXC_LEN);
            default:     n_len = '0;
        endcase
    end

    // Response byte at position r_k
    assign hdr_k  = (r_k < K_W'(HDR_LEN)) ? r_hdr[r_k[HDR_AW-1:0]] : 8'h00;
    assign rd_val = (r_rd_addr < 17'(NUM_REGS)) ? r_regs[r_rd_addr[ADDR_W-1:0]] : 16'd0;
    assign two_q  = 8'({r_qty, 1'b0});

    always_comb begin
        n_byte = hdr_k;
        if (r_mode != MODE_ECHO) begin
            case (r_k) inside
                [K_W'(2):K_W'(4)]: n_byte = 8'h00;
                K_W'(POS_LEN_LO): begin
                    case (r_mode)
                        MODE_READ:   n_byte = LEN_SHORT_PDU + two_q;
                        MODE_WMULTI: n_byte = LEN_WRITE_PDU;
                        default:     n_byte = LEN_SHORT_PDU;
                    endcase
                end
                K_W'(POS_FUNC): begin
                    if (r_mode == MODE_EXC) begin
                        n_byte = hdr_k | EXC_FLAG;
                    end
                end
                K_W'(POS_ARG): begin
                    if (r_mode == MODE_READ) begin
                        n_byte = two_q;
                    end else if (r_mode == MODE_EXC) begin
                        n_byte = EXC_ILLEGAL_FN;
                    end
                end
                default: begin
                    if ((r_mode == MODE_READ) && (r_k >= K_W'(POS_DATA))) begin
                        n_byte = r_k[0] ? rd_val[15:8] : rd_val[7:0];
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_sts.no_resp   = (n_mode == MODE_NONE);
        o_sts.last_byte = (r_k == r_len - K_W'(1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Header bytes, decision results and output byte: written in place, no reset
    always_ff @(posedge i_clk) begin
        if (take_en && (r_pos < POS_W'(HDR_LEN))) begin
            r_hdr[r_pos[HDR_AW-1:0]] <= i_req_byte;
        end
        if (i_cmd.decide) begin
            r_qty     <= n_qty;
            r_len     <= n_len;
        end
        if (i_cmd.emit) begin
            r_out_byte <= n_byte;
            r_out_end  <= o_sts.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= REG_PRESET[i];
            end
        end else if (wr_en) begin
            r_regs[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_pend      <= '0;
            r_widx      <= '0;
            r_mode      <= MODE_NONE;
            r_k         <= '0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_en) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (hi_byte) begin
                r_pend <= i_req_byte;
            end
            if (word_done) begin
                r_widx <= r_widx + IDX_W'(1);
            end
            if (i_cmd.decide) begin
                r_pos     <= '0;
                r_pend    <= '0;
                r_widx    <= '0;
                r_mode    <= n_mode;
                r_k       <= '0;
                r_rd_addr <= 17'(hdr_start);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_k         <= r_k + K_W'(1);
                // advance the read address after each low data byte
                if ((r_mode == MODE_READ) && (r_k > K_W'(POS_DATA)) && !r_k[0]) begin
                    r_rd_addr <= r_rd_addr + 17'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_resp_byte = r_out_byte;
    assign o_resp_end  = r_out_end;

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> ((r_k < r_len) && (r_len <= K_W'(MAX_RESP))))
        else $error("response byte index out of range");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

endmodule

// File: design/modbus_tcp_register_server.sv
// Channel    Direction  Handshake           Payload
// request    in         i_valid / o_ready   i_req_byte, i_frame_end
// response   out        o_valid / i_ready   o_resp_byte, o_resp_end
//
// A request byte is taken only while the server is idle.
// A byte with frame end moves it to a decision state, then the response
// goes out byte by byte (9 to 29 bytes) while the output register drains.
// Reset (synchronous, active low) presets the ten holding registers and
// clears the byte counter; the header bytes hold until written.
// A stalled response holds the output register; no request byte is taken
// until the whole response has been loaded.
module modbus_tcp_register_server (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_req_byte,
    input  logic       i_frame_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_resp_byte,
    output logic       o_resp_end
);
    import mbtrs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: intake, decision, byte-by-byte response
    mbtrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_frame_end (i_frame_end),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_ready     (o_ready)
    );

    // Header store, register table, response builder and output register
    mbtrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_byte  (i_req_byte),
        .i_out_ready (i_ready),
        .o_sts       (sts),
        .o_out_valid (o_valid),
        .o_resp_byte (o_resp_byte),
        .o_resp_end  (o_resp_end)
    );

endmodule

// File: tb/tb_modbus_tcp_register_server.sv
`timescale 1ns / 1ps

module tb_modbus_tcp_register_server;
    import mbtrs_pkg::*;

    // Server geometry as the bench sees it
    localparam int REG_COUNT    = 10;
    localparam int FRAME_CAP    = 512;
    localparam int HDR_BYTES    = 12;
    localparam int RESP_CAP     = 29;
    localparam int RANDOM_BYTES = 245;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    // How the response of a directed frame is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // predicted
        CHK_TYPED,   // typed in below
        CHK_ECHO,    // first twelve request bytes come back
        CHK_SILENT   // no response at all
    } t_chk;

    // Frame and typed response are written left to right, byte 0 first
    typedef struct packed {
        logic [159:0] frame;
        logic [7:0]   nbytes;
        t_chk         chk;
        logic [127:0] resp;
        logic [7:0]   rlen;
    } t_frame_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_resp_beat;

    localparam int ROWS = 13;

    // Directed frames: protocol extremes, every function, every exception path
    t_frame_row directed_frames [ROWS] = '{
        // read two registers straight after reset: presets 123 and 456
        '{160'(96'h0001_0000_0006_1103_0000_0002), 8'd12, CHK_TYPED,
          128'(104'h0001_0000_0007_1103_04_007B_01C8), 8'd13},
        // read with quantity 0xFFFF: clamp to ten, addresses past the table read 0
        '{160'(96'h0002_0000_0006_0103_0008_FFFF), 8'd12, CHK_MODEL, 128'h0, 8'd0},
        // write single, top register, all ones
        '{160'(96'h0003_0000_0006_FF06_0009_FFFF), 8'd12, CHK_ECHO, 128'h0, 8'd0},
        // write single to an address far out of range: echo only
        '{160'(96'hFFFF_0000_0006_0006_FFFF_0000), 8'd12, CHK_ECHO, 128'h0, 8'd0},
        // write multiple, quantity 3 but the third word is cut short
        '{160'(144'h0005_0000_000B_0110_0000_0003_06_FFFF_0000_5A), 8'd18, CHK_MODEL,
          128'h0, 8'd0},
        // unknown function 0xFF
        '{160'(64'h0006_0000_0002_07FF), 8'd8, CHK_TYPED,
          128'(72'h0006_0000_0003_07FF_01), 8'd9},
        // read one byte short of a full request
        '{160'(88'h0007_0000_0005_0703_0000_00), 8'd11, CHK_TYPED,
          128'(72'h0007_0000_0003_0783_01), 8'd9},
        // write multiple without the byte count
        '{160'(96'h0008_0000_0006_0710_0000_0001), 8'd12, CHK_TYPED,
          128'(72'h0008_0000_0003_0790_01), 8'd9},
        // single byte frame
        '{160'(8'hFF), 8'd1, CHK_SILENT, 128'h0, 8'd0},
        // seven byte frame
        '{160'(56'h0009_0000_0001_03), 8'd7, CHK_SILENT, 128'h0, 8'd0},
        // nonzero protocol id on a write: must not touch register 0
        '{160'(96'h000A_0100_0006_0106_0000_0000), 8'd12, CHK_SILENT, 128'h0, 8'd0},
        // function code 0: exception byte is plain 0x80
        '{160'(64'h000C_0000_0002_0100), 8'd8, CHK_TYPED,
          128'(72'h000C_0000_0003_0180_01), 8'd9},
        // read the whole table back to see every write so far
        '{160'(96'h000B_0000_0006_0103_0000_000A), 8'd12, CHK_MODEL, 128'h0, 8'd0}
    };

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_req_byte  = 8'h00;
    logic       i_frame_end = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_resp_byte;
    logic       o_resp_end;

    // Register server shadow
    logic [7:0]  hdr [HDR_BYTES];
    logic [15:0] regs [REG_COUNT];
    int          frame_pos;
    logic [7:0]  word_hi;
    logic [7:0]  resp_built [$];

    // Scoreboard
    t_resp_beat  pending_resp_bytes [$];
    t_frame_row  frame_checks [$];
    logic [7:0]  frame_q [$];
    int          mismatches = 0;

    // Idle mix and the long receiver hold-off
    int          send_idle = 14;
    int          recv_idle = 56;
    logic        hold_req  = 1'b0;
    int          hold_left = 0;

    modbus_tcp_register_server dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_byte  (i_req_byte),
        .i_frame_end (i_frame_end),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_resp_byte (o_resp_byte),
        .o_resp_end  (o_resp_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the server
    // ------------------------------------------------------------------

    task automatic shadow_reset();
        frame_pos = 0;
        word_hi   = 8'h00;
        for (int k = 0; k < HDR_BYTES; k++) hdr[k] = 8'h00;
        regs = '{16'd123, 16'd456, 16'd789, 16'd321, 16'd654,
                 16'd987, 16'd111, 16'd222, 16'd333, 16'd444};
    endtask

    function automatic logic [15:0] hdr_pair(int at);
        return {hdr[at], hdr[at + 1]};
    endfunction

    task automatic store_reg(int unsigned addr, logic [15:0] value);
        if (addr < REG_COUNT) regs[addr] = value;
    endtask

    // Take one request byte; when it closes the frame, leave the response in resp_built
    task automatic serve_byte(logic [7:0] b, logic last);
        int         p;
        int         off;
        int         q;
        int         n;
        int unsigned a;
        logic [15:0] v;
        logic [7:0] r [RESP_CAP];
        resp_built.delete();
        // drop bytes past the frame cap, but let their frame end still count
        if (frame_pos < FRAME_CAP) begin
            p = frame_pos;
            if (p < HDR_BYTES) hdr[p] = b;
            // write multiple: each data word lands when its low byte arrives
            if (p >= 13 && hdr_pair(2) == 16'h0000 && hdr[POS_FUNC] == FUNC_WRITE_MUL) begin
                off = p - 13;
                if (off % 2 == 0) begin
                    word_hi = b;
                end else if ((off / 2) < hdr_pair(10)) begin
                    store_reg(hdr_pair(8) + off / 2, {word_hi, b});
                end
            end
            frame_pos = p + 1;
        end
        if (!last) return;
        // short frames and foreign protocol ids go unanswered
        if (frame_pos >= 8 && hdr_pair(2) == 16'h0000) begin
            for (int k = 0; k < RESP_CAP; k++) r[k] = 8'h00;
            r[0] = hdr[0];
            r[1] = hdr[1];
            r[6] = hdr[6];
            r[7] = hdr[POS_FUNC];
            if (hdr[POS_FUNC] == FUNC_READ && frame_pos >= 12) begin
                q = int'(hdr_pair(10));
                if (q > 10) q = 10;
                r[5] = 8'(LEN_SHORT_PDU + 2 * q);
                r[8] = 8'(2 * q);
                for (int k = 0; k < q; k++) begin
                    a = hdr_pair(8) + k;
                    v = (a < REG_COUNT) ? regs[a] : 16'h0000;
                    r[9 + 2 * k]  = v[15:8];
                    r[10 + 2 * k] = v[7:0];
                end
                n = 9 + 2 * q;
            end else if (hdr[POS_FUNC] == FUNC_WRITE_ONE && frame_pos >= 12) begin
                store_reg(hdr_pair(8), hdr_pair(10));
                for (int k = 0; k < HDR_BYTES; k++) r[k] = hdr[k];
                n = 12;
            end else if (hdr[POS_FUNC] == FUNC_WRITE_MUL && frame_pos >= 13) begin
                r[5] = LEN_WRITE_PDU;
                for (int k = 8; k < 12; k++) r[k] = hdr[k];
                n = 12;
            end else begin
                r[5] = LEN_SHORT_PDU;
                r[7] = hdr[POS_FUNC] | EXC_FLAG;
                r[8] = EXC_ILLEGAL_FN;
                n = 9;
            end
            for (int k = 0; k < n; k++) resp_built.push_back(r[k]);
        end
        frame_pos = 0;
        word_hi   = 8'h00;
    endtask

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Advance the shadow on every request transaction; queue the response at frame end
    always @(posedge i_clk) begin : request_mon
        t_frame_row row;
        int         nb;
        if (i_rst_n && i_valid && o_ready) begin
            serve_byte(i_req_byte, i_frame_end);
            if (i_frame_end) begin
                // directed frames carry their own check; the shadow still advances
                if (frame_checks.size() != 0) begin
                    row = frame_checks.pop_front();
                    if (row.chk != CHK_MODEL) begin
                        resp_built.delete();
                        if (row.chk == CHK_TYPED) begin
                            nb = int'(row.rlen);
                            for (int k = 0; k < nb; k++)
                                resp_built.push_back(row.resp[8 * (nb - 1 - k) +: 8]);
                        end else if (row.chk == CHK_ECHO) begin
                            nb = int'(row.nbytes);
                            for (int k = 0; k < HDR_BYTES; k++)
                                resp_built.push_back(row.frame[8 * (nb - 1 - k) +: 8]);
                        end
                    end
                end
                for (int k = 0; k < resp_built.size(); k++)
                    pending_resp_bytes.push_back('{resp_built[k], k == resp_built.size() - 1});
            end
        end
    end

    // Compare each response transaction against the oldest expected byte
    always @(posedge i_clk) begin : response_mon
        t_resp_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_resp_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected response byte %h end %b",
                             $realtime, o_resp_byte, o_resp_end);
            end else begin
                want = pending_resp_bytes.pop_front();
                if (want.data !== o_resp_byte || want.last !== o_resp_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response byte %h end %b, expected %h end %b",
                                 $realtime, o_resp_byte, o_resp_end, want.data, want.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one byte; return at the edge that accepts it, valid still high
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_byte  <= b;
        i_frame_end <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_frame();
        for (int j = 0; j < frame_q.size(); j++)
            send_byte(frame_q[j], j == frame_q.size() - 1);
    endtask

    // Drop valid and hold until every queued response byte has come back
    task automatic settle_responses();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_resp_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_byte(logic [7:0] b);
        frame_q.push_back(b);
    endtask

    task automatic put_word(logic [15:0] w);
        frame_q.push_back(w[15:8]);
        frame_q.push_back(w[7:0]);
    endtask

    // Mostly addresses around the table, now and then anything
    function automatic logic [15:0] pick_addr();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(11));
    endfunction

    function automatic logic [15:0] pick_qty();
        return ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    endfunction

    // One random frame: mostly well-formed requests, some broken ones
    task automatic build_random_frame();
        int          kind;
        int          fsel;
        int          cut;
        logic [7:0]  f;
        logic [15:0] proto;
        frame_q.delete();
        kind  = $urandom_range(99);
        proto = (kind >= 94) ? 16'($urandom_range(16'hFFFF, 1)) : 16'h0000;
        put_word(16'($urandom));
        put_word(proto);
        put_word(16'($urandom));
        put_byte(8'($urandom));
        if (kind < 30) fsel = 0;
        else if (kind < 55) fsel = 1;
        else if (kind < 80) fsel = 2;
        else if (kind < 94) fsel = 3;
        else fsel = $urandom_range(2);
        case (fsel)
            0, 1: begin
                put_byte(fsel == 0 ? FUNC_READ : FUNC_WRITE_ONE);
                put_word(pick_addr());
                put_word(fsel == 0 ? pick_qty() : 16'($urandom));
                // trailing bytes are ignored
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(3, 1)) put_byte(8'($urandom));
            end
            2: begin
                put_byte(FUNC_WRITE_MUL);
                put_word(pick_addr());
                put_word(pick_qty());
                put_byte(8'($urandom));
                repeat ($urandom_range(25)) put_byte(8'($urandom));
            end
            default: begin
                // unknown function, or a known one cut short
                case ($urandom_range(2))
                    0: begin
                        do f = 8'($urandom);
                        while (f == FUNC_READ || f == FUNC_WRITE_ONE || f == FUNC_WRITE_MUL);
                        put_byte(f);
                        repeat ($urandom_range(6)) put_byte(8'($urandom));
                    end
                    1: begin
                        put_byte($urandom_range(1) ? FUNC_READ : FUNC_WRITE_ONE);
                        repeat ($urandom_range(3)) put_byte(8'($urandom));
                    end
                    default: begin
                        put_byte(FUNC_WRITE_MUL);
                        repeat ($urandom_range(4)) put_byte(8'($urandom));
                    end
                endcase
            end
        endcase
        // runt frame: keep only the first few bytes
        if (kind >= 88 && kind < 94) begin
            cut = $urandom_range(7, 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    initial begin : stimulus
        int sent;
        int nb;
        bit paused;
        shadow_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames, each with its check queued ahead of it
        for (int r = 0; r < ROWS; r++) begin
            frame_q.delete();
            nb = int'(directed_frames[r].nbytes);
            for (int j = 0; j < nb; j++)
                frame_q.push_back(directed_frames[r].frame[8 * (nb - 1 - j) +: 8]);
            frame_checks.push_back(directed_frames[r]);
            send_frame();
        end
        settle_responses();

        // Hold the response side off while frames keep arriving, so the
        // server backs up and stalls its request side
        hold_req = 1'b1;

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BYTES) begin
            if (sent >= 2 * RANDOM_BYTES / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= RANDOM_BYTES / 3) begin
                send_idle = 56;
                recv_idle = 14;
            end
            // pause the sender once until the server has fully drained
            if (!paused && sent >= RANDOM_BYTES / 2) begin
                settle_responses();
                paused = 1'b1;
            end
            build_random_frame();
            send_frame();
            sent += frame_q.size();
        end

        // Drain, then watch a while longer for stray response bytes
        settle_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_resp_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
